// File: sv/assert_macros.svh
// Shared assertion macros for the IMU low-pass block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define ASSERT_NEVER(LBL, CK, RSTN, COND, MSG) \
	LBL: assert property (@(posedge CK) disable iff (!RSTN) !(COND)) else $error(MSG);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(LBL, CK, RSTN, ANT, CONS) \
	LBL: assert property (@(posedge CK) disable iff (!RSTN) (ANT) |-> (CONS)) else $error("implication failed");

`endif

// File: sv/imulp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imulp_pkg;

	localparam int CHANNELS   = 6;
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int NUM_REGS   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GAIN_W     = 23;
	localparam int COEF_W     = 24;
	localparam int INT_W      = 32;
	localparam int ACC_W      = 64;
	// internal scale: sample * 2^(STATE_TOP - SAMPLE_BITS), two guard bits
	localparam int STATE_TOP  = 30;
	localparam int OWED_W     = 2;

	localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS - 1);
	localparam logic [OWED_W-1:0] OWED_MAX  = OWED_W'(2);
	localparam logic [INT_W-1:0]  INT_MAX_V = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic [INT_W-1:0]  INT_MIN_V = {1'b1, {(INT_W-1){1'b0}}};

	localparam logic [GAIN_W-1:0] RST_GAIN = GAIN_W'(1002900);
	localparam logic [COEF_W-1:0] RST_B0   = COEF_W'(84234);
	localparam logic [COEF_W-1:0] RST_B1   = COEF_W'(168468);
	localparam logic [COEF_W-1:0] RST_B2   = COEF_W'(84234);
	localparam logic [COEF_W-1:0] RST_A1   = COEF_W'(-6547407);
	localparam logic [COEF_W-1:0] RST_A2   = COEF_W'(2689918);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_MODE = 3'd0,
		REG_SMOOTH_GAIN = 3'd1,
		REG_COEF_B0     = 3'd2,
		REG_COEF_B1     = 3'd3,
		REG_COEF_B2     = 3'd4,
		REG_COEF_A1     = 3'd5,
		REG_COEF_A2     = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		MODE_FIRST_ORDER = 1'b0,
		MODE_BIQUAD      = 1'b1
	} filter_mode_t;

	typedef struct packed {
		filter_mode_t      mode;
		logic [GAIN_W-1:0] gain;
		logic [COEF_W-1:0] b0;
		logic [COEF_W-1:0] b1;
		logic [COEF_W-1:0] b2;
		logic [COEF_W-1:0] a1;
		logic [COEF_W-1:0] a2;
	} coef_t;

	// one channel operation moving down the pipeline
	typedef struct packed {
		logic            valid;
		logic [CH_W-1:0] ch;
		logic            seed;
		logic            last;
	} op_ctl_t;

endpackage

`default_nettype wire

// File: sv/imulp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module imulp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/imulp_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imulp_seq
	import imulp_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample [CHANNELS],
	input  logic                          cfg_clear,
	input  logic                          deliver,
	output op_ctl_t                       iss,
	output logic signed [SAMPLE_BITS-1:0] iss_x
);

	logic signed [SAMPLE_BITS-1:0] pend_q [CHANNELS];
	logic                          pend_v_q;
	logic                          pend_seed_q;
	logic                          primed_q;
	logic [CH_W-1:0]               ch_q;
	logic [OWED_W-1:0]             owed_q;
	logic                          issue;
	logic                          last;
	logic                          start;
	logic                          accept;

	// hold a new request back at channel zero while two results are still owed
	always_comb begin
		last      = (ch_q == LAST_CH);
		issue     = pend_v_q && ((ch_q != '0) || (owed_q < OWED_MAX));
		start     = issue && (ch_q == '0);
		in_ready  = !pend_v_q || (issue && last);
		accept    = in_valid && in_ready;
		iss.valid = issue;
		iss.ch    = ch_q;
		iss.seed  = pend_seed_q;
		iss.last  = last;
		iss_x     = pend_q[ch_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			primed_q <= 1'b0;
			ch_q     <= '0;
			owed_q   <= '0;
		end else begin
			if (accept) begin
				pend_v_q <= 1'b1;
			end else if (issue && last) begin
				pend_v_q <= 1'b0;
			end
			if (issue) begin
				ch_q <= last ? '0 : ch_q + 1'b1;
			end
			if (cfg_clear) begin
				primed_q <= 1'b0;
			end else if (accept) begin
				primed_q <= 1'b1;
			end
			if (start && !deliver) begin
				owed_q <= owed_q + 1'b1;
			end else if (!start && deliver) begin
				owed_q <= owed_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q      <= in_sample;
			pend_seed_q <= !primed_q;
		end
	end

	`ASSERT_NEVER(a_owed_bound, clk, arst_n, owed_q > OWED_MAX, "owed result count above two")
	`ASSERT_IMPLY(a_mid_item_data, clk, arst_n, ch_q != '0, pend_v_q)

endmodule

`default_nettype wire

// File: sv/imulp_mac.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imulp_mac
	import imulp_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 22,
	localparam int SF    = STATE_TOP - SAMPLE_BITS,
	localparam int MEM_W = 3 * INT_W + 2 * SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  coef_t                         coef,
	input  op_ctl_t                       iss,
	input  logic signed [SAMPLE_BITS-1:0] iss_x,
	input  logic [MEM_W-1:0]              rdata,
	output logic                          wen,
	output logic [CH_W-1:0]               waddr,
	output logic [MEM_W-1:0]              wdata,
	output op_ctl_t                       res,
	output logic signed [SAMPLE_BITS-1:0] res_sample
);

	localparam int OFS_D1 = SAMPLE_BITS;
	localparam int OFS_Y2 = 2 * SAMPLE_BITS;
	localparam int OFS_Y1 = 2 * SAMPLE_BITS + INT_W;
	localparam int OFS_SV = 2 * SAMPLE_BITS + 2 * INT_W;
	localparam int GUARD  = INT_W - STATE_TOP;
	localparam logic [ACC_W-1:0] RND_ACC = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [INT_W:0]   RND_OUT = (INT_W + 1)'(1) << (SF - 1);

	op_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [ACC_W-1:0]       pa_s2, pb_s2, pc_s2, pd_s2, pe_s2;
	logic [MEM_W-1:0]              hist_s2, hist_s3, hist_s4;
	logic signed [ACC_W-1:0]       sp_s3, sn_s3;
	logic signed [INT_W-1:0]       v_s4;

	logic                                biq;
	logic signed [INT_W-1:0]             xs, sv, y1, y2;
	logic signed [SAMPLE_BITS-1:0]       d1, d2;
	logic signed [INT_W:0]               diff;
	logic signed [INT_W:0]               opb_l;
	logic signed [COEF_W-1:0]            opb_r;
	logic signed [COEF_W+SAMPLE_BITS-1:0] m0, m2;
	logic signed [INT_W+COEF_W:0]        mb;
	logic signed [INT_W+COEF_W-1:0]      m3, m4;
	logic signed [ACC_W-1:0]             pa, pb, pc, pd, pe;
	logic [MEM_W-1:0]                    hist;
	logic signed [ACC_W-1:0]             acc, q;
	logic                                sat32_hi, sat32_lo;
	logic signed [INT_W-1:0]             v;
	logic signed [INT_W:0]               t_out, o;
	logic                                satx_hi, satx_lo;
	logic signed [INT_W-1:0]             sv_w, y1_w;

	assign biq = (coef.mode == MODE_BIQUAD);

	// s1: seed or take the stored history, form the five products
	always_comb begin
		xs = {{GUARD{x_s1[SAMPLE_BITS-1]}}, x_s1, {SF{1'b0}}};
		sv = ctl_s1.seed ? xs : $signed(rdata[OFS_SV +: INT_W]);
		y1 = ctl_s1.seed ? xs : $signed(rdata[OFS_Y1 +: INT_W]);
		y2 = ctl_s1.seed ? xs : $signed(rdata[OFS_Y2 +: INT_W]);
		d1 = ctl_s1.seed ? x_s1 : $signed(rdata[OFS_D1 +: SAMPLE_BITS]);
		d2 = ctl_s1.seed ? x_s1 : $signed(rdata[0 +: SAMPLE_BITS]);
		diff  = (INT_W + 1)'(xs) - (INT_W + 1)'(sv);
		opb_l = biq ? (INT_W + 1)'(d1) : diff;
		opb_r = biq ? $signed(coef.b1) : $signed({1'b0, coef.gain});
		m0 = $signed(coef.b0) * x_s1;
		mb = opb_l * opb_r;
		m2 = $signed(coef.b2) * d2;
		m3 = $signed(coef.a1) * y1;
		m4 = $signed(coef.a2) * y2;
		pa = biq ? (ACC_W'(m0) <<< SF) : (ACC_W'(sv) <<< COEF_FRAC_BITS);
		pb = biq ? (ACC_W'(mb) <<< SF) : ACC_W'(mb);
		pc = biq ? (ACC_W'(m2) <<< SF) : '0;
		pd = biq ? ACC_W'(m3) : '0;
		pe = biq ? ACC_W'(m4) : '0;
		// shift the delay lines in biquad mode, keep them otherwise
		hist = biq ? {sv, y1, y1, x_s1, d1} : {sv, y1, y2, d1, d2};
	end

	// s3: combine, round, saturate to the internal range
	always_comb begin
		acc      = sp_s3 - sn_s3;
		q        = acc >>> COEF_FRAC_BITS;
		sat32_hi = !q[ACC_W-1] && (|q[ACC_W-2:INT_W-1]);
		sat32_lo = q[ACC_W-1] && !(&q[ACC_W-2:INT_W-1]);
		if (sat32_hi) begin
			v = $signed(INT_MAX_V);
		end else if (sat32_lo) begin
			v = $signed(INT_MIN_V);
		end else begin
			v = q[INT_W-1:0];
		end
	end

	// s4: write back and scale down to a sample
	always_comb begin
		t_out   = (INT_W + 1)'(v_s4) + $signed(RND_OUT);
		o       = t_out >>> SF;
		satx_hi = !o[INT_W] && (|o[INT_W-1:SAMPLE_BITS-1]);
		satx_lo = o[INT_W] && !(&o[INT_W-1:SAMPLE_BITS-1]);
		if (satx_hi) begin
			res_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (satx_lo) begin
			res_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			res_sample = o[SAMPLE_BITS-1:0];
		end
		sv_w  = biq ? $signed(hist_s4[OFS_SV +: INT_W]) : v_s4;
		y1_w  = biq ? v_s4 : $signed(hist_s4[OFS_Y1 +: INT_W]);
		wdata = {sv_w, y1_w, hist_s4[OFS_Y1-1:0]};
		wen   = ctl_s4.valid;
		waddr = ctl_s4.ch;
		res   = ctl_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= iss;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= iss_x;
		pa_s2   <= pa;
		pb_s2   <= pb;
		pc_s2   <= pc;
		pd_s2   <= pd;
		pe_s2   <= pe;
		hist_s2 <= hist;
		sp_s3   <= pa_s2 + pb_s2 + pc_s2 + $signed(RND_ACC);
		sn_s3   <= pd_s2 + pe_s2;
		hist_s3 <= hist_s2;
		v_s4    <= v;
		hist_s4 <= hist_s3;
	end

	`ASSERT_NEVER(a_rmw_overlap, clk, arst_n, iss.valid && ((ctl_s1.valid && ctl_s1.ch == iss.ch) || (ctl_s2.valid && ctl_s2.ch == iss.ch) || (ctl_s3.valid && ctl_s3.ch == iss.ch) || (ctl_s4.valid && ctl_s4.ch == iss.ch)), "channel read while its update is in flight")

endmodule

`default_nettype wire

// File: sv/imulp_out.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imulp_out
	import imulp_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  op_ctl_t                       res,
	input  logic signed [SAMPLE_BITS-1:0] res_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample [CHANNELS]
);

	logic signed [SAMPLE_BITS-1:0] asm_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] asm_next [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] out_q [CHANNELS];
	logic                          asm_full_q;
	logic                          out_valid_q;
	logic                          out_free;
	logic                          done_now;
	logic                          move_asm;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		done_now = res.valid && res.last;
		move_asm = asm_full_q && out_free;
	end

	// assembled set including the channel that arrives this cycle
	always_comb begin
		asm_next = asm_q;
		if (res.valid) begin
			asm_next[res.ch] = res_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_now) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					asm_full_q <= 1'b1;
				end
			end else if (move_asm) begin
				out_valid_q <= 1'b1;
				asm_full_q  <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			asm_q[res.ch] <= res_sample;
		end
		if (done_now && out_free) begin
			out_q <= asm_next;
		end else if (move_asm) begin
			out_q <= asm_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	`ASSERT_NEVER(a_asm_overrun, clk, arst_n, res.valid && asm_full_q, "result arrived while assembly buffer full")

endmodule

`default_nettype wire

// File: sv/six_channel_imu_lowpass_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Six-channel IMU low-pass filter. Each request carries one sample set (accel x/y/z, gyro
// x/y/z); each result carries the six filtered samples, rounded and saturated. Register 0
// selects a first-order smoother (mode 0) or a Butterworth-style direct-form-I biquad
// (mode 1); registers 1..6 hold alpha (UQ1.22) and b0, b1, b2, a1, a2 (Q2.22) from software.
// Write registers only while the block is idle; any write to an index in the list makes the
// next request seed every channel's history with its own samples. A request passes through
// the shared multiply-accumulate pipeline one channel per cycle once its first channel
// issues, and the single state RAM is read and written once per channel. A new request is
// taken while the previous result still waits. Up to two results may be pending on the
// output side before new requests are held back. The state RAM needs no clearing pass
// after reset: the first request after reset is always seeded.
module six_channel_imu_lowpass_top
	import imulp_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic signed [SAMPLE_BITS-1:0] gyro_x,
	input  logic signed [SAMPLE_BITS-1:0] gyro_y,
	input  logic signed [SAMPLE_BITS-1:0] gyro_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] accel_x_out,
	output logic signed [SAMPLE_BITS-1:0] accel_y_out,
	output logic signed [SAMPLE_BITS-1:0] accel_z_out,
	output logic signed [SAMPLE_BITS-1:0] gyro_x_out,
	output logic signed [SAMPLE_BITS-1:0] gyro_y_out,
	output logic signed [SAMPLE_BITS-1:0] gyro_z_out,
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	// per-channel state word: smoother value, two output delays, two input delays
	localparam int MEM_W = 3 * INT_W + 2 * SAMPLE_BITS;

	coef_t                         coef_q;
	logic                          cfg_clear;
	logic signed [SAMPLE_BITS-1:0] in_sample  [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] out_sample [CHANNELS];
	op_ctl_t                       iss;
	op_ctl_t                       res;
	logic signed [SAMPLE_BITS-1:0] iss_x;
	logic signed [SAMPLE_BITS-1:0] res_sample;
	logic [MEM_W-1:0]              rdata;
	logic [MEM_W-1:0]              wdata;
	logic                          wen;
	logic [CH_W-1:0]               waddr;

	// a write beyond the register list is dropped and leaves the seeding state alone
	assign cfg_clear = cfg_write_en && (cfg_index < CFG_IDX_W'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.mode <= MODE_FIRST_ORDER;
			coef_q.gain <= RST_GAIN;
			coef_q.b0   <= RST_B0;
			coef_q.b1   <= RST_B1;
			coef_q.b2   <= RST_B2;
			coef_q.a1   <= RST_A1;
			coef_q.a2   <= RST_A2;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FILTER_MODE: coef_q.mode <= filter_mode_t'(cfg_data[0]);
				REG_SMOOTH_GAIN: coef_q.gain <= cfg_data[GAIN_W-1:0];
				REG_COEF_B0:     coef_q.b0   <= cfg_data[COEF_W-1:0];
				REG_COEF_B1:     coef_q.b1   <= cfg_data[COEF_W-1:0];
				REG_COEF_B2:     coef_q.b2   <= cfg_data[COEF_W-1:0];
				REG_COEF_A1:     coef_q.a1   <= cfg_data[COEF_W-1:0];
				REG_COEF_A2:     coef_q.a2   <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// channel order: accel x, y, z, then gyro x, y, z
	assign in_sample[0] = accel_x;
	assign in_sample[1] = accel_y;
	assign in_sample[2] = accel_z;
	assign in_sample[3] = gyro_x;
	assign in_sample[4] = gyro_y;
	assign in_sample[5] = gyro_z;

	// request buffer and channel sequencer; drives the RAM read address
	imulp_seq #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.cfg_clear (cfg_clear),
		.deliver   (out_valid && out_ready),
		.iss       (iss),
		.iss_x     (iss_x)
	);

	// state RAM: one word per channel, read at issue, written back from pipeline stage s4
	imulp_ram #(
		.WIDTH(MEM_W),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (iss.ch),
		.rdata (rdata)
	);

	// shared multiply-accumulate pipeline: products, sums, round and saturate, write back
	imulp_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef_q),
		.iss        (iss),
		.iss_x      (iss_x),
		.rdata      (rdata),
		.wen        (wen),
		.waddr      (waddr),
		.wdata      (wdata),
		.res        (res),
		.res_sample (res_sample)
	);

	// gather the six channel results and hold them in the output register
	imulp_out #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.res_sample (res_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample)
	);

	assign accel_x_out = out_sample[0];
	assign accel_y_out = out_sample[1];
	assign accel_z_out = out_sample[2];
	assign gyro_x_out  = out_sample[3];
	assign gyro_y_out  = out_sample[4];
	assign gyro_z_out  = out_sample[5];

endmodule

`default_nettype wire

// File: tb/imu_lowpass_monitor.sv
`timescale 1ns / 1ps

module imu_lowpass_monitor
	import imulp_pkg::*;
#(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] raw_set,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] filtered_set,
	input  logic                                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data,
	output int                                    mismatches,
	output int                                    pending
);

	localparam int     STATE_FRAC   = STATE_TOP - SAMPLE_BITS;
	localparam longint STATE_SCALE  = longint'(1) << STATE_FRAC;
	localparam longint COEF_ONE     = longint'(1) << COEF_FRAC_BITS;
	localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
	localparam longint LEVEL_MAX    = longint'(2147483647);
	localparam longint LEVEL_MIN    = -LEVEL_MAX - 1;
	localparam int     REPORT_LIMIT = 10;

	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_set_t;

	filter_mode_t mode;
	longint       gain, b0, b1, b2, a1, a2;
	logic         primed;
	int           smooth_val [CHANNELS];
	int           x_prev1 [CHANNELS];
	int           x_prev2 [CHANNELS];
	int           y_prev1 [CHANNELS];
	int           y_prev2 [CHANNELS];
	sample_set_t  filtered_due [$];

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic int saturate32(longint v);
		if (v > LEVEL_MAX)
			return int'(LEVEL_MAX);
		if (v < LEVEL_MIN)
			return int'(LEVEL_MIN);
		return int'(v);
	endfunction

	function automatic string channel_name(int ch);
		case (ch)
			0: return "accel_x";
			1: return "accel_y";
			2: return "accel_z";
			3: return "gyro_x";
			4: return "gyro_y";
			default: return "gyro_z";
		endcase
	endfunction

	task automatic lowpass_step(input sample_set_t raw, output sample_set_t filtered);
		longint x, xs, acc, level;
		int     v;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			x  = longint'($signed(raw[ch]));
			xs = x * STATE_SCALE;
			if (!primed) begin
				smooth_val[ch] = int'(xs);
				x_prev1[ch]    = int'(x);
				x_prev2[ch]    = int'(x);
				y_prev1[ch]    = int'(xs);
				y_prev2[ch]    = int'(xs);
			end
			if (mode == MODE_FIRST_ORDER) begin
				acc = longint'(smooth_val[ch]) * COEF_ONE
					+ (xs - longint'(smooth_val[ch])) * gain;
				v = saturate32(round_shift(acc, COEF_FRAC_BITS));
				smooth_val[ch] = v;
			end else begin
				acc = b0 * xs
					+ b1 * (longint'(x_prev1[ch]) * STATE_SCALE)
					+ b2 * (longint'(x_prev2[ch]) * STATE_SCALE)
					- a1 * longint'(y_prev1[ch])
					- a2 * longint'(y_prev2[ch]);
				v = saturate32(round_shift(acc, COEF_FRAC_BITS));
				x_prev2[ch] = x_prev1[ch];
				x_prev1[ch] = int'(x);
				y_prev2[ch] = y_prev1[ch];
				y_prev1[ch] = v;
			end
			level = round_shift(longint'(v), STATE_FRAC);
			if (level > SAMPLE_MAX)
				level = SAMPLE_MAX;
			else if (level < SAMPLE_MIN)
				level = SAMPLE_MIN;
			filtered[ch] = level[SAMPLE_BITS-1:0];
		end
		primed = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sample_set_t want, next_due;
		if (!arst_n) begin
			mode   = MODE_FIRST_ORDER;
			gain   = longint'(RST_GAIN);
			b0     = longint'($signed(RST_B0));
			b1     = longint'($signed(RST_B1));
			b2     = longint'($signed(RST_B2));
			a1     = longint'($signed(RST_A1));
			a2     = longint'($signed(RST_A2));
			primed = 1'b0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				smooth_val[ch] = 0;
				x_prev1[ch]    = 0;
				x_prev2[ch]    = 0;
				y_prev1[ch]    = 0;
				y_prev2[ch]    = 0;
			end
			filtered_due.delete();
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with no request outstanding", $time);
				end else begin
					want = filtered_due.pop_front();
					for (int ch = 0; ch < CHANNELS; ch++)
						if (filtered_set[ch] !== want[ch]) begin
							mismatches++;
							if (mismatches <= REPORT_LIMIT)
								$display("%0t: %s expected %0d got %0d", $time,
									channel_name(ch), $signed(want[ch]),
									$signed(filtered_set[ch]));
						end
				end
			end
			if (in_valid && in_ready) begin
				lowpass_step(raw_set, next_due);
				filtered_due.push_back(next_due);
			end
			// writes beyond the register list leave the history alone
			if (cfg_write_en && cfg_index < NUM_REGS) begin
				primed = 1'b0;
				case (cfg_index)
					REG_FILTER_MODE: mode = filter_mode_t'(cfg_data[0]);
					REG_SMOOTH_GAIN: gain = longint'(cfg_data[GAIN_W-1:0]);
					REG_COEF_B0:     b0 = longint'($signed(cfg_data[COEF_W-1:0]));
					REG_COEF_B1:     b1 = longint'($signed(cfg_data[COEF_W-1:0]));
					REG_COEF_B2:     b2 = longint'($signed(cfg_data[COEF_W-1:0]));
					REG_COEF_A1:     a1 = longint'($signed(cfg_data[COEF_W-1:0]));
					default:         a2 = longint'($signed(cfg_data[COEF_W-1:0]));
				endcase
			end
			pending <= filtered_due.size();
		end
	end

endmodule

// File: tb/six_channel_imu_lowpass_top_tb.sv
`timescale 1ns / 1ps

module six_channel_imu_lowpass_top_tb;
	import imulp_pkg::*;

	localparam int SAMPLE_W      = 16;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = 30;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 64;
	localparam int UNITY         = 4194304;  // 1.0 in Q2.22
	localparam int POLE_LIMIT    = 3984588;  // 0.95 in Q2.22

	// index past the end of the register list: the block must ignore it
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_W'(NUM_REGS);

	localparam logic [SAMPLE_W-1:0] S_MAX  = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] S_MIN  = 16'h8000;
	localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;

	localparam logic [CFG_DATA_W-1:0] DATA_ONES   = 24'hFFFFFF;
	localparam logic [CFG_DATA_W-1:0] DATA_LOW0   = 24'hFFFFFE;
	localparam logic [CFG_DATA_W-1:0] DATA_ZERO   = 24'h000000;
	localparam logic [CFG_DATA_W-1:0] COEF_MAX    = 24'h7FFFFF;
	localparam logic [CFG_DATA_W-1:0] COEF_MIN    = 24'h800000;

	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] imu_set_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] accel_x, accel_y, accel_z;
	logic signed [SAMPLE_W-1:0] gyro_x, gyro_y, gyro_z;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] accel_x_out, accel_y_out, accel_z_out;
	logic signed [SAMPLE_W-1:0] gyro_x_out, gyro_y_out, gyro_z_out;
	logic                       cfg_write_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	int   fail_count;
	int   pending;
	int   hold_requests;
	int   cycle_count;
	logic sender_calm;
	logic receiver_calm;
	logic signed [SAMPLE_W-1:0] walk [CHANNELS];

	six_channel_imu_lowpass_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.gyro_x       (gyro_x),
		.gyro_y       (gyro_y),
		.gyro_z       (gyro_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accel_x_out  (accel_x_out),
		.accel_y_out  (accel_y_out),
		.accel_z_out  (accel_z_out),
		.gyro_x_out   (gyro_x_out),
		.gyro_y_out   (gyro_y_out),
		.gyro_z_out   (gyro_z_out),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Channel 0 sits in the low bits: accel x, y, z, then gyro x, y, z.
	imu_lowpass_monitor lowpass_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_set      ({gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x}),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.filtered_set ({gyro_z_out, gyro_y_out, gyro_x_out,
			accel_z_out, accel_y_out, accel_x_out}),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Mostly back-to-back, sometimes a few cycles, now and then a long gap.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Alpha: mostly a usable blend, sometimes a slow one, sometimes any 24-bit pattern
	// (bit 23 must be dropped, leaving gains of up to just under 2.0).
	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return CFG_DATA_W'($urandom_range(0, UNITY));
		if (roll < 8)
			return CFG_DATA_W'($urandom_range(0, UNITY / 16));
		return CFG_DATA_W'($urandom);
	endfunction

	// Sensor-like data: each channel drifts as a random walk, with full-range noise
	// and rail hits mixed in.
	function automatic imu_set_t next_samples();
		imu_set_t set;
		int       roll;
		longint   moved;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				moved = longint'(walk[ch]) + longint'($urandom_range(0, 2048)) - 1024;
				if (moved > 32767)
					moved = 32767;
				else if (moved < -32768)
					moved = -32768;
				walk[ch] = SAMPLE_W'(moved);
			end else if (roll < 92) begin
				walk[ch] = SAMPLE_W'($urandom);
			end else begin
				walk[ch] = roll[0] ? S_MAX : S_MIN;
			end
			set[ch] = walk[ch];
		end
		return set;
	endfunction

	// Offer one request and hold it until the block takes it.
	task automatic send_set(input imu_set_t set);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x  <= set[0];
		accel_y  <= set[1];
		accel_z  <= set[2];
		gyro_x   <= set[3];
		gyro_y   <= set[4];
		gyro_z   <= set[5];
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drop valid and wait until every result owed has come back, then let the
	// pipeline settle before anything touches the registers.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Stable low-pass section built from two real poles inside +-0.95, with the
	// numerator 1-2-1 shaped and scaled to unit DC gain.
	task automatic load_stable_biquad();
		longint pole_a, pole_b, fb1, fb2, dc, ff0, ff1;
		pole_a = longint'($urandom_range(0, 2 * POLE_LIMIT)) - POLE_LIMIT;
		pole_b = longint'($urandom_range(0, 2 * POLE_LIMIT)) - POLE_LIMIT;
		fb1    = -(pole_a + pole_b);
		fb2    = (pole_a * pole_b) >>> 22;
		dc     = longint'(UNITY) + fb1 + fb2;
		ff0    = dc >>> 2;
		ff1    = dc >>> 1;
		write_reg(REG_COEF_B0, CFG_DATA_W'(ff0));
		write_reg(REG_COEF_B1, CFG_DATA_W'(ff1));
		write_reg(REG_COEF_B2, CFG_DATA_W'(dc - ff0 - ff1));
		write_reg(REG_COEF_A1, CFG_DATA_W'(fb1));
		write_reg(REG_COEF_A2, CFG_DATA_W'(fb2));
	endtask

	// Receiver: random stalls, calm stretches, and a long hold-off whenever the
	// stimulus asks for one, counted here so the sender keeps pushing meanwhile.
	initial begin : receiver
		int stall_left;
		int holds_served;
		stall_left   = 0;
		holds_served = 0;
		out_ready    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				stall_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (receiver_calm || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int roll;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		accel_x       = '0;
		accel_y       = '0;
		accel_z       = '0;
		gyro_x        = '0;
		gyro_y        = '0;
		gyro_z        = '0;
		cfg_write_en  = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		receiver_calm = 1'b0;
		sender_calm   = 1'b0;
		hold_requests = 0;
		for (int ch = 0; ch < CHANNELS; ch++)
			walk[ch] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, first-order smoother: the first request seeds the history,
		// then hit both rails and alternate them across channels.
		send_set({16'h3039, 16'h0001, 16'hFFFF, S_ZERO, S_MIN, S_MAX});
		send_set({6{S_MIN}});
		send_set({6{S_MAX}});
		send_set({S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN});
		send_set({6{S_ZERO}});

		// Biquad with the reset coefficients; a full-scale step overshoots the rail.
		wait_idle();
		write_reg(REG_FILTER_MODE, DATA_ONES);
		send_set({6{S_MIN}});
		send_set({6{S_MAX}});
		send_set({6{S_MAX}});
		send_set({6{S_MIN}});
		send_set({S_MIN, S_ZERO, S_MAX, 16'h1234, 16'hEDCC, S_ZERO});

		// Back to first order with alpha just under 2.0: every step overshoots.
		wait_idle();
		write_reg(REG_FILTER_MODE, DATA_LOW0);
		write_reg(REG_SMOOTH_GAIN, DATA_ONES);
		send_set({6{S_MIN}});
		send_set({6{S_MAX}});
		send_set({6{S_MIN}});
		send_set({6{S_ZERO}});

		// Biquad with coefficients at their extremes: the state runs into the
		// 32-bit limits.
		wait_idle();
		write_reg(REG_FILTER_MODE, DATA_ONES);
		write_reg(REG_COEF_B0, COEF_MAX);
		write_reg(REG_COEF_B1, COEF_MIN);
		write_reg(REG_COEF_B2, COEF_MAX);
		write_reg(REG_COEF_A1, COEF_MIN);
		write_reg(REG_COEF_A2, COEF_MAX);
		send_set({6{S_MAX}});
		send_set({6{S_MIN}});
		send_set({6{S_MAX}});
		send_set({S_MIN, S_MAX, S_ZERO, S_MAX, S_MIN, 16'h0001});

		// Seed a well-behaved biquad at one rail, then write past the register list:
		// the history must survive, so the next request still sees the old rail.
		wait_idle();
		write_reg(REG_COEF_B0, CFG_DATA_W'(RST_B0));
		write_reg(REG_COEF_B1, CFG_DATA_W'(RST_B1));
		write_reg(REG_COEF_B2, CFG_DATA_W'(RST_B2));
		write_reg(REG_COEF_A1, CFG_DATA_W'(RST_A1));
		write_reg(REG_COEF_A2, CFG_DATA_W'(RST_A2));
		send_set({6{S_MAX}});
		wait_idle();
		write_reg(IDX_UNUSED, DATA_ONES);
		send_set({6{S_MIN}});
		send_set({6{S_MIN}});

		// Zero alpha: the smoother holds its seed whatever comes in.
		wait_idle();
		write_reg(REG_FILTER_MODE, DATA_ZERO);
		write_reg(REG_SMOOTH_GAIN, DATA_ZERO);
		send_set({6{16'h03E8}});
		send_set({6{S_MAX}});
		send_set({6{S_MIN}});

		// Random phases: new settings each time, then a run of sensor-like requests.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			if ($urandom_range(0, 3) == 0)
				write_reg(IDX_UNUSED, CFG_DATA_W'($urandom));
			write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom));
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_SMOOTH_GAIN, pick_gain());
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				load_stable_biquad();
			end else if (roll < 9) begin
				for (int r = REG_COEF_B0; r <= REG_COEF_A2; r++)
					write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
			end

			sender_calm    = (phase % 4 == 1);
			receiver_calm <= (phase % 4 == 2);

			for (int item = 0; item < PHASE_ITEMS; item++) begin
				// long receiver hold-off while requests keep coming: the block
				// must fill up and push back on its input
				if ((phase == 3 || phase == 7) && item == 8)
					hold_requests <= hold_requests + 1;
				// pause the sender until every result is back, history kept
				if (phase == 5 && item == PHASE_ITEMS / 2)
					wait_idle();
				send_set(next_samples());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
